// ===== rtl/sgig_pkg.sv =====
package sgig_pkg;

    localparam int IndexWidth = 17;
    localparam int QuadWidth  = 9;

    // region codes, also the value of the walk region counter
    localparam logic [2:0] REGION_SURFACE = 3'd0;
    localparam logic [2:0] REGION_UMIN    = 3'd1;
    localparam logic [2:0] REGION_UMAX    = 3'd2;
    localparam logic [2:0] REGION_VMIN    = 3'd3;
    localparam logic [2:0] REGION_VMAX    = 3'd4;

    // configuration register indexes
    localparam logic REG_QUAD_COUNT  = 1'b0;
    localparam logic REG_STITCH_MASK = 1'b1;

    localparam logic [8:0] QUAD_COUNT_RESET = 9'd64;

    typedef logic [IndexWidth-1:0] index_t;

    typedef struct packed {
        logic [2:0] region;
        logic [8:0] col;
        logic [8:0] row;
        logic       last;
    } walk_pos_t;

endpackage

// ===== rtl/stitched_grid_index_generator.sv =====
// channel   | ports          | contents (lowest bits first)
// ----------+----------------+-------------------------------------------------
// input     | s_t*           | tdata: restart[0], zero padding
// output    | m_t*           | tdata: index_a..index_f (17 bits each); tuser: region;
//           |                | tlast: last_pair
// config    | APB            | 0x0 quad_count, 0x4 stitch_mask
//
// one transaction in, one out; a new transaction is taken every cycle while the output is not stalled
// pipeline stages: walk counter step, row and skirt base multiply,
// corner adds into the output register
// the three stages stall together only where the stage ahead is full and stalled
// aresetn (synchronous) clears the walk counters, the stage valids and the configuration registers
module stitched_grid_index_generator import sgig_pkg::*; #(
    parameter int MAX_QUADS = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    // restart
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,
    // index_a, index_b, index_c, index_d, index_e, index_f
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,
    // region
    output logic [2:0]   m_tuser,
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [8:0] quad_count_reg;
    logic [3:0] stitch_mask_reg;
    logic [8:0] q;
    index_t     n17;

    logic [2:0] walk_region_reg, walk_region_next;
    logic [8:0] column_or_sample_reg, column_or_sample_next;
    logic [8:0] row_counter_reg, row_counter_next;

    logic       v1_reg, v2_reg, v3_reg;
    logic       rdy1, rdy2, rdy3;
    walk_pos_t  s1_reg, s1_next;
    walk_pos_t  s2_reg;
    index_t     prod_reg, nn_reg, en_reg;
    logic [8:0] mul_sel;
    index_t     en_next;

    index_t     idx_a, idx_b, idx_c, idx_d, idx_e, idx_f;
    logic [103:0] tdata_reg;
    logic [2:0]   tuser_reg;
    logic         tlast_reg;

    // ---------------- configuration ----------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quad_count_reg  <= QUAD_COUNT_RESET;
            stitch_mask_reg <= 4'd0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_QUAD_COUNT:  quad_count_reg  <= pwdata[8:0];
                REG_STITCH_MASK: stitch_mask_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_QUAD_COUNT:  prdata = {23'd0, quad_count_reg};
            REG_STITCH_MASK: prdata = {28'd0, stitch_mask_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // effective quad count: zero reads as one, saturate at the build limit
    always_comb begin
        if (quad_count_reg == 9'd0) begin
            q = 9'd1;
        end else if (32'(quad_count_reg) > 32'(MAX_QUADS)) begin
            q = QuadWidth'(MAX_QUADS);
        end else begin
            q = quad_count_reg;
        end
    end

    assign n17 = IndexWidth'(q) + 17'd1;

    // ---------------- handshake ----------------
    assign rdy3     = !v3_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    // ---------------- stage 1: walk counters ----------------
    always_comb begin
        logic       bad;
        logic [9:0] col_inc;
        logic [9:0] row_inc;
        bad = (walk_region_reg > REGION_VMAX) || (column_or_sample_reg >= q) ||
              ((walk_region_reg == REGION_SURFACE) && (row_counter_reg >= q));
        if (s_tdata[0] || bad) begin
            s1_next.region = REGION_SURFACE;
            s1_next.col    = 9'd0;
            s1_next.row    = 9'd0;
        end else begin
            s1_next.region = walk_region_reg;
            s1_next.col    = column_or_sample_reg;
            s1_next.row    = row_counter_reg;
        end
        s1_next.last = 1'b0;

        walk_region_next      = s1_next.region;
        column_or_sample_next = s1_next.col;
        row_counter_next      = s1_next.row;
        col_inc = {1'b0, s1_next.col} + 10'd1;
        row_inc = {1'b0, s1_next.row} + 10'd1;
        if (col_inc >= {1'b0, q}) begin
            column_or_sample_next = 9'd0;
            if (s1_next.region == REGION_SURFACE) begin
                if (row_inc >= {1'b0, q}) begin
                    row_counter_next = 9'd0;
                    walk_region_next = REGION_UMIN;
                end else begin
                    row_counter_next = row_inc[8:0];
                end
            end else if (s1_next.region == REGION_VMAX) begin
                walk_region_next = REGION_SURFACE;
                s1_next.last     = 1'b1;
            end else begin
                walk_region_next = s1_next.region + 3'd1;
            end
        end else begin
            column_or_sample_next = col_inc[8:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_region_reg      <= REGION_SURFACE;
            column_or_sample_reg <= 9'd0;
            row_counter_reg      <= 9'd0;
        end else if (s_tvalid && rdy1) begin
            walk_region_reg      <= walk_region_next;
            column_or_sample_reg <= column_or_sample_next;
            row_counter_reg      <= row_counter_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) s1_reg <= s1_next;
    end

    // ---------------- stage 2: row and skirt bases ----------------
    always_comb begin
        unique case (s1_reg.region)
            REGION_SURFACE: mul_sel = s1_reg.row;
            REGION_UMIN,
            REGION_UMAX:    mul_sel = s1_reg.col;
            REGION_VMAX:    mul_sel = q;
            default:        mul_sel = 9'd0;
        endcase
        unique case (s1_reg.region)
            REGION_UMAX: en_next = n17;
            REGION_VMIN: en_next = n17 << 1;
            REGION_VMAX: en_next = (n17 << 1) + n17;
            default:     en_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            s2_reg   <= s1_reg;
            prod_reg <= IndexWidth'(mul_sel * n17[9:0]);
            nn_reg   <= IndexWidth'(n17[9:0] * n17[9:0]);
            en_reg   <= en_next;
        end
    end

    // ---------------- stage 3: corner indices ----------------
    // stitched edges pull odd samples back to the even one before them
    function automatic index_t surf_corner(
        input logic [9:0] cx,
        input logic [9:0] cy,
        input logic [8:0] y,
        input index_t     rb,
        input index_t     n,
        input logic [8:0] qe,
        input logic [3:0] mask
    );
        logic [9:0] ax;
        logic [9:0] ay;
        index_t     base;
        ax = cx;
        ay = cy;
        if (mask[0] && ax == 10'd0 && ay[0]) begin
            ay = ay - 10'd1;
        end else if (mask[1] && ax == {1'b0, qe} && ay[0]) begin
            ay = ay - 10'd1;
        end
        if (mask[2] && ay == 10'd0 && ax[0]) begin
            ax = ax - 10'd1;
        end else if (mask[3] && ay == {1'b0, qe} && ax[0]) begin
            ax = ax - 10'd1;
        end
        if (ay == {1'b0, y} + 10'd1) begin
            base = rb + n;
        end else if (ay == {1'b0, y}) begin
            base = rb;
        end else begin
            base = rb - n;
        end
        return base + IndexWidth'(ax);
    endfunction

    always_comb begin
        logic [9:0] x0, x1, y0, y1;
        logic       st;
        logic [9:0] src, dst;
        index_t     t0, t1, k0, k1, skb;
        x0 = {1'b0, s2_reg.col};
        x1 = x0 + 10'd1;
        y0 = {1'b0, s2_reg.row};
        y1 = y0 + 10'd1;
        st  = 1'b0;
        src = x0;
        dst = x1;
        t0  = '0;
        t1  = '0;
        skb = nn_reg + en_reg;
        if (s2_reg.region != REGION_SURFACE) begin
            st = stitch_mask_reg[2'(s2_reg.region - 3'd1)];
        end
        if (st && x0[0]) src = x0 - 10'd1;
        if (st && !x0[0]) dst = x0;
        k0 = skb + IndexWidth'(src);
        k1 = skb + IndexWidth'(dst);

        unique case (s2_reg.region)
            REGION_UMIN,
            REGION_UMAX: begin
                t0 = (src == x0) ? prod_reg : prod_reg - n17;
                t1 = (dst == x0) ? prod_reg : prod_reg + n17;
                if (s2_reg.region == REGION_UMAX) begin
                    t0 = t0 + IndexWidth'(q);
                    t1 = t1 + IndexWidth'(q);
                end
            end
            default: begin
                t0 = prod_reg + IndexWidth'(src);
                t1 = prod_reg + IndexWidth'(dst);
            end
        endcase

        if (s2_reg.region == REGION_SURFACE) begin
            idx_a = surf_corner(x0, y0, s2_reg.row, prod_reg, n17, q, stitch_mask_reg);
            idx_b = surf_corner(x1, y0, s2_reg.row, prod_reg, n17, q, stitch_mask_reg);
            idx_c = surf_corner(x1, y1, s2_reg.row, prod_reg, n17, q, stitch_mask_reg);
            idx_f = surf_corner(x0, y1, s2_reg.row, prod_reg, n17, q, stitch_mask_reg);
        end else begin
            idx_a = t0;
            idx_b = t1;
            idx_c = k1;
            idx_f = k0;
        end
        idx_d = idx_a;
        idx_e = idx_c;
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            tdata_reg <= {2'b00, idx_f, idx_e, idx_d, idx_c, idx_b, idx_a};
            tuser_reg <= s2_reg.region;
            tlast_reg <= s2_reg.last;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tlast  = tlast_reg;

endmodule

// ===== verif/stitched_grid_index_checker.sv =====
`timescale 1ns / 1ps

module stitched_grid_index_checker import sgig_pkg::*; #(
    parameter int MAX_QUADS = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,
    input  logic [2:0]   m_tuser,
    input  logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           mismatch_count,
    output int           pairs_in_flight
);

    typedef struct packed {
        index_t [5:0] corner;
        logic [2:0]   region;
        logic         last;
    } index_pair_t;

    logic [8:0] quad_cfg;
    logic [3:0] stitch_cfg;
    logic [2:0] walk_region;
    logic [8:0] walk_col;
    logic [8:0] walk_row;

    index_pair_t pending_pairs[$];
    int          mismatches;

    initial begin
        mismatches = 0;
    end

    function automatic int unsigned effective_quads();
        if (quad_cfg == 9'd0) begin
            return 1;
        end
        if (quad_cfg > MAX_QUADS) begin
            return MAX_QUADS;
        end
        return quad_cfg;
    endfunction

    function automatic logic side_stitched(input logic [2:0] region);
        return stitch_cfg[2'(region - REGION_UMIN)];
    endfunction

    function automatic int unsigned grid_vertex(input int unsigned q, x, y);
        return y * (q + 1) + x;
    endfunction

    // odd samples on stitched edges fold onto the even sample before them
    function automatic int unsigned snapped_vertex(input int unsigned q, x, y);
        int unsigned sx;
        int unsigned sy;
        sx = x;
        sy = y;
        if (side_stitched(REGION_UMIN) && sx == 0 && sy[0]) sy--;
        if (side_stitched(REGION_UMAX) && sx == q && sy[0]) sy--;
        if (side_stitched(REGION_VMIN) && sy == 0 && sx[0]) sx--;
        if (side_stitched(REGION_VMAX) && sy == q && sx[0]) sx--;
        return grid_vertex(q, sx, sy);
    endfunction

    function automatic int unsigned rim_vertex(input int unsigned q, input logic [2:0] region,
                                               input int unsigned s);
        case (region)
            REGION_UMIN: return grid_vertex(q, 0, s);
            REGION_UMAX: return grid_vertex(q, q, s);
            REGION_VMIN: return grid_vertex(q, s, 0);
            default:     return grid_vertex(q, s, q);
        endcase
    endfunction

    function automatic int unsigned skirt_vertex(input int unsigned q, input logic [2:0] region,
                                                 input int unsigned s);
        int unsigned n;
        n = q + 1;
        return n * n + (region - REGION_UMIN) * n + s;
    endfunction

    function automatic index_pair_t next_index_pair(input logic restart);
        index_pair_t pair;
        int unsigned q;
        int unsigned s;
        int unsigned src;
        int unsigned dst;
        int unsigned tl;
        int unsigned tr;
        int unsigned bl;
        int unsigned br;
        logic        walk_stale;
        q = effective_quads();
        walk_stale = walk_region > REGION_VMAX || walk_col >= q ||
                     (walk_region == REGION_SURFACE && walk_row >= q);
        if (restart || walk_stale) begin
            walk_region = REGION_SURFACE;
            walk_col    = '0;
            walk_row    = '0;
        end
        if (walk_region == REGION_SURFACE) begin
            tl = snapped_vertex(q, walk_col, walk_row);
            tr = snapped_vertex(q, walk_col + 1, walk_row);
            bl = snapped_vertex(q, walk_col, walk_row + 1);
            br = snapped_vertex(q, walk_col + 1, walk_row + 1);
            pair.corner[0] = index_t'(tl);
            pair.corner[1] = index_t'(tr);
            pair.corner[2] = index_t'(br);
            pair.corner[3] = index_t'(tl);
            pair.corner[4] = index_t'(br);
            pair.corner[5] = index_t'(bl);
        end else begin
            s   = walk_col;
            src = (side_stitched(walk_region) && s[0]) ? s - 1 : s;
            dst = (side_stitched(walk_region) && !s[0]) ? s : s + 1;
            pair.corner[0] = index_t'(rim_vertex(q, walk_region, src));
            pair.corner[1] = index_t'(rim_vertex(q, walk_region, dst));
            pair.corner[2] = index_t'(skirt_vertex(q, walk_region, dst));
            pair.corner[3] = index_t'(rim_vertex(q, walk_region, src));
            pair.corner[4] = index_t'(skirt_vertex(q, walk_region, dst));
            pair.corner[5] = index_t'(skirt_vertex(q, walk_region, src));
        end
        pair.region = walk_region;
        pair.last   = 1'b0;

        walk_col = walk_col + 9'd1;
        if (walk_region == REGION_SURFACE) begin
            if (walk_col >= q) begin
                walk_col = '0;
                walk_row = walk_row + 9'd1;
                if (walk_row >= q) begin
                    walk_row    = '0;
                    walk_region = REGION_UMIN;
                end
            end
        end else if (walk_col >= q) begin
            walk_col = '0;
            if (walk_region == REGION_VMAX) begin
                walk_region = REGION_SURFACE;
                pair.last   = 1'b1;
            end else begin
                walk_region = walk_region + 3'd1;
            end
        end
        return pair;
    endfunction

    always @(posedge aclk) begin : track
        index_pair_t want;
        index_pair_t fresh;
        if (!aresetn) begin
            quad_cfg    = QUAD_COUNT_RESET;
            stitch_cfg  = '0;
            walk_region = REGION_SURFACE;
            walk_col    = '0;
            walk_row    = '0;
            pending_pairs.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    {REG_QUAD_COUNT, 2'b00}:  quad_cfg   = pwdata[8:0];
                    {REG_STITCH_MASK, 2'b00}: stitch_cfg = pwdata[3:0];
                    default: ;
                endcase
            end
            // pop before push so a same-edge pair never meets its own expectation
            if (m_tvalid && m_tready) begin
                if (pending_pairs.size() == 0) begin
                    $error("index pair transaction with nothing expected");
                    mismatches++;
                end else begin
                    want = pending_pairs.pop_front();
                    for (int i = 0; i < 6; i++) begin
                        if (m_tdata[IndexWidth*i +: IndexWidth] !== want.corner[i]) begin
                            $error("index_%c: expected %0d, actual %0d", 8'h61 + i,
                                   want.corner[i], m_tdata[IndexWidth*i +: IndexWidth]);
                            mismatches++;
                        end
                    end
                    if (m_tuser !== want.region) begin
                        $error("region: expected %0d, actual %0d", want.region, m_tuser);
                        mismatches++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_pair: expected %0d, actual %0d", want.last, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                fresh = next_index_pair(s_tdata[0]);
                pending_pairs.insert(pending_pairs.size(), fresh);
            end
        end
        mismatch_count  <= mismatches;
        pairs_in_flight <= pending_pairs.size();
    end

endmodule

// ===== verif/tb_stitched_grid_index_generator.sv =====
`timescale 1ns / 1ps

module tb_stitched_grid_index_generator;
    import sgig_pkg::*;

    localparam int MaxQuads       = 256;
    localparam int RandomSteps    = 1350;
    localparam int QuietTail      = 200;
    localparam int LongHoldCycles = 80;
    localparam int CycleLimit     = 300000;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = '0;     // restart[0], zero padding
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;           // index_a..index_f, 17 bits each, zero padding
    logic [2:0]   m_tuser;           // region
    logic         m_tlast;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [2:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;

    int mismatch_count;
    int pairs_in_flight;

    // idling controls shared by sender and receiver
    bit quiet             = 1'b0;
    bit calm              = 1'b0;
    bit long_hold_request = 1'b0;

    always #2 aclk = ~aclk;

    stitched_grid_index_generator #(.MAX_QUADS(MaxQuads)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    stitched_grid_index_checker #(.MAX_QUADS(MaxQuads)) checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatch_count  (mismatch_count),
        .pairs_in_flight (pairs_in_flight)
    );

    task automatic write_reg(input logic reg_index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic offer_step(input logic restart);
        if (!(quiet || calm) && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, restart};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic offer_run(input int count, input logic restart);
        repeat (count) offer_step(restart);
        s_tvalid <= 1'b0;
    endtask

    // sender stays silent until every pair in flight has come out
    task automatic wait_drained();
        do @(posedge aclk); while (pairs_in_flight != 0);
    endtask

    // receiver
    initial begin
        @(posedge aclk);
        forever begin
            if (long_hold_request) begin
                long_hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LongHoldCycles) @(posedge aclk);
            end else if (!(quiet || calm) && $urandom_range(0, 11) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CycleLimit) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb_stitched_grid_index_generator: done, errors");
        $finish;
    end

    initial begin
        int  sent;
        int  n;
        int  q;
        int  eff_q;
        int  patch;
        int  pick;
        logic [3:0] mask;
        bit  hold_done;
        sent      = 0;
        q         = QUAD_COUNT_RESET;
        hold_done = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values, then a restart in the middle of the first row
        offer_run(3, 1'b0);
        offer_run(1, 1'b1);
        wait_drained();
        // single quad: one full patch and the wrap
        write_reg(REG_QUAD_COUNT, 32'd1);
        write_reg(REG_STITCH_MASK, 32'd0);
        offer_run(6, 1'b0);
        wait_drained();
        // zero quad count behaves as one, all edges stitched
        write_reg(REG_QUAD_COUNT, 32'd0);
        write_reg(REG_STITCH_MASK, 32'hF);
        offer_run(2, 1'b1);
        wait_drained();
        write_reg(REG_QUAD_COUNT, 32'd2);
        offer_run(12, 1'b1);
        wait_drained();
        // quad count saturates above the build limit
        write_reg(REG_QUAD_COUNT, 32'h1FF);
        write_reg(REG_STITCH_MASK, 32'hA);
        offer_run(1, 1'b0);
        wait_drained();
        // column now beyond the shrunken patch
        write_reg(REG_QUAD_COUNT, 32'hFFFF_FE01);
        offer_run(1, 1'b0);
        q = 1;

        while (sent < RandomSteps) begin
            wait_drained();
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) != 0) begin
                pick = $urandom_range(0, 19);
                case (pick)
                    0:       q = 0;
                    1:       q = MaxQuads;
                    2:       q = $urandom_range(MaxQuads + 1, 510);
                    3:       q = 511;
                    4, 5, 6: q = $urandom_range(9, 16);
                    default: q = $urandom_range(1, 8);
                endcase
                write_reg(REG_QUAD_COUNT, ($urandom() & 32'hFFFF_FE00) | 32'(q));
            end
            if ($urandom_range(0, 3) != 0) begin
                pick = $urandom_range(0, 5);
                mask = (pick == 0) ? 4'h0 : (pick == 1) ? 4'hF : 4'($urandom());
                write_reg(REG_STITCH_MASK, ($urandom() & 32'hFFFF_FFF0) | 32'(mask));
            end
            eff_q = (q == 0) ? 1 : (q > MaxQuads) ? MaxQuads : q;
            patch = eff_q * eff_q + 4 * eff_q;
            if (patch > 600) begin
                n = $urandom_range(10, 300);
            end else if ($urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, patch);
            end else begin
                n = patch + $urandom_range(0, patch / 2);
            end
            if (n > 500) n = 500;
            if (n > RandomSteps - sent) n = RandomSteps - sent;
            if (!hold_done && sent >= 300 && n >= 20) begin
                long_hold_request = 1'b1;
                hold_done         = 1'b1;
            end
            for (int i = 0; i < n; i++) begin
                if (sent >= RandomSteps - QuietTail) quiet = 1'b1;
                offer_step($urandom_range(0, 29) == 0);
                sent++;
            end
            s_tvalid <= 1'b0;
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_stitched_grid_index_generator: done, clean");
        end else begin
            $display("tb_stitched_grid_index_generator: done, errors");
        end
        $finish;
    end

endmodule
